// ===== rtl/bfw_pkg.sv =====
// ---------------------------------------------------------------------------
// bfw_pkg
// Shared types, constants and the exponential weight table of the
// streaming bilateral filter.
// ---------------------------------------------------------------------------
`default_nettype none

package bfw_pkg;

    localparam int MAX_RADIUS    = 7;
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PIXEL_BITS    = 16;
    localparam int EXP_DEPTH     = 1024;
    localparam int WIN           = 2 * MAX_RADIUS + 1;
    localparam int LINES         = 2 * MAX_RADIUS;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
    localparam int WIN_BITS      = $clog2(WIN);
    localparam int RAD_BITS      = 3;
    localparam int DIM_BITS      = 13;
    localparam int KS_BITS       = 16;
    localparam int KR_BITS       = 24;
    localparam int CFG_BITS      = 24;
    localparam int EXP_IDX_BITS  = $clog2(EXP_DEPTH);
    localparam int EXP_SPAN_BITS = 12;
    localparam int WT_BITS       = 17;
    localparam int DIST2_BITS    = 7;
    localparam int WSUM_BITS     = 25;
    localparam int PSUM_BITS     = 40;
    localparam int QUOT_BITS     = 17;

    // table step 16/EXP_DEPTH in Q32
    localparam longint unsigned EXP_STEP_Q32 = (64'd16 << 32) / EXP_DEPTH;

    // square of the full-scale sample, 65535 * 65535
    localparam logic [31:0] PIX_SQ_MAX = 32'hFFFE_0001;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef t_pix [WIN-1:0]        t_column;
    typedef t_pix [LINES-1:0]      t_lines;
    typedef logic [WT_BITS-1:0]    t_wt;
    typedef t_wt                   t_exp_rom [EXP_DEPTH];

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_RADIUS       = 3'd2,
        CFG_SPATIAL_COEF = 3'd3,
        CFG_RANGE_COEF   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TAPS,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } t_state;

    // one window tap handed to the weight pipeline
    typedef struct packed {
        logic                  valid;
        t_pix                  tap;
        t_pix                  centre;
        logic [DIST2_BITS-1:0] dist2;
    } t_tap_req;

    // weighted tap leaving the weight pipeline
    typedef struct packed {
        logic                          valid;
        t_wt                           wt;
        logic [WT_BITS+PIXEL_BITS-1:0] prod;
    } t_wt_out;

    // long division for building the table, floored quotient
    function automatic longint unsigned div_u64(longint unsigned num,
                                                longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-16*i/EXP_DEPTH) in Q16, built from a Q32 step value
    function automatic t_exp_rom exp_rom_build();
        t_exp_rom          rom;
        longint unsigned   one;
        longint unsigned   h;
        longint unsigned   t;
        longint unsigned   e;
        longint unsigned   q;
        one = 64'd1 << 32;
        h   = EXP_STEP_Q32;
        t   = one;
        e   = one;
        q   = one;
        for (int k = 1; k <= 10; k++) begin
            t = div_u64((t * h) >> 32, longint'(k));
            if (k % 2 == 1) begin
                e = e - t;
            end else begin
                e = e + t;
            end
        end
        for (int i = 0; i < EXP_DEPTH; i++) begin
            rom[i] = WT_BITS'((q + 64'd32768) >> 16);
            q = (q * e + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bfw_stream_if.sv =====
// ---------------------------------------------------------------------------
// bfw stream interfaces
// Valid/ready channels for incoming samples and filtered results.
// ---------------------------------------------------------------------------
`default_nettype none

interface bfw_in_if;
    logic          valid;
    logic          ready;
    bfw_pkg::t_pix pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface bfw_out_if;
    logic          valid;
    logic          ready;
    bfw_pkg::t_pix pixel_out;
    logic          frame_done;
    modport source (output valid, output pixel_out, output frame_done, input ready);
    modport sink (input valid, input pixel_out, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfw_column_cell.sv =====
// ---------------------------------------------------------------------------
// bfw_column_cell
// One column of the filter window; takes the column of its right
// neighbor on every new sample.
// ---------------------------------------------------------------------------
`default_nettype none

module bfw_column_cell (
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  wire bfw_pkg::t_column i_col,
    output bfw_pkg::t_column      o_col
);

    bfw_pkg::t_column r_col;

    // column shift toward the left
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// ===== rtl/bfw_weight_unit.sv =====
// ---------------------------------------------------------------------------
// bfw_weight_unit
// Pipelined weight for one tap per cycle: range and spatial exponent,
// exponential table lookup and weighted sample product.
// ---------------------------------------------------------------------------
`default_nettype none

module bfw_weight_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [bfw_pkg::KS_BITS-1:0]   i_ks,
    input  wire logic [bfw_pkg::KR_BITS-1:0]   i_kr,
    input  wire bfw_pkg::t_tap_req             i_req,
    output bfw_pkg::t_wt_out                   o_wt,
    output logic                               o_busy
);

    localparam int STAGES = 7;
    localparam int SP_BITS = bfw_pkg::KS_BITS + bfw_pkg::DIST2_BITS;
    localparam int P_BITS = bfw_pkg::KR_BITS + 2 * bfw_pkg::PIXEL_BITS;
    localparam int PL_BITS = bfw_pkg::EXP_SPAN_BITS + 32;
    localparam int A_BITS = SP_BITS + 1;
    localparam bfw_pkg::t_exp_rom EXP_ROM = bfw_pkg::exp_rom_build();

    logic [STAGES-1:0]   r_v;
    bfw_pkg::t_pix       r_tap [STAGES];

    logic [bfw_pkg::PIXEL_BITS-1:0]   r_d1;
    logic [bfw_pkg::DIST2_BITS-1:0]   r_s2_1;
    logic [2*bfw_pkg::PIXEL_BITS-1:0] r_d2_2;
    logic [SP_BITS-1:0]               r_sp2;
    logic [P_BITS-1:0]                r_p3;
    logic [SP_BITS-1:0]               r_sp3;
    logic [PL_BITS-1:0]               r_p4;
    logic [PL_BITS-1:0]               r_m4;
    logic [bfw_pkg::EXP_SPAN_BITS-1:0] r_q0_4;
    logic                             r_big4;
    logic [SP_BITS-1:0]               r_sp4;
    logic [bfw_pkg::EXP_IDX_BITS-1:0] r_idx5;
    logic                             r_zero5;
    bfw_pkg::t_wt                     r_rom6;
    logic                             r_zero6;
    bfw_pkg::t_wt                     r_wt7;
    logic [bfw_pkg::WT_BITS+bfw_pkg::PIXEL_BITS-1:0] r_prod7;

    logic [PL_BITS-1:0] rem5;
    logic [A_BITS-1:0]  a5;
    logic [bfw_pkg::EXP_SPAN_BITS:0] q5;
    bfw_pkg::t_wt       wt6;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[STAGES-2:0], i_req.valid};
        end
    end

    // tap sample travels beside the weight
    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_req.tap;
        for (int s = 1; s < STAGES; s++) begin
            r_tap[s] <= r_tap[s-1];
        end
    end

    // exponent remainder and range term quotient
    always_comb begin
        rem5 = r_p4 - r_m4;
        q5   = {1'b0, r_q0_4} + ((rem5 >= PL_BITS'(bfw_pkg::PIX_SQ_MAX)) ? 1'b1 : 1'b0);
        a5   = A_BITS'(r_sp4) + A_BITS'(q5);
        wt6  = r_zero6 ? '0 : r_rom6;
    end

    // exponent and weight stages
    always_ff @(posedge i_clk) begin
        r_d1    <= (i_req.tap > i_req.centre) ? i_req.tap - i_req.centre
                                              : i_req.centre - i_req.tap;
        r_s2_1  <= i_req.dist2;
        r_d2_2  <= r_d1 * r_d1;
        r_sp2   <= SP_BITS'(i_ks) * SP_BITS'(r_s2_1);
        r_p3    <= P_BITS'(i_kr) * P_BITS'(r_d2_2);
        r_sp3   <= r_sp2;
        r_p4    <= r_p3[PL_BITS-1:0];
        r_q0_4  <= r_p3[PL_BITS-1:32];
        r_big4  <= |r_p3[P_BITS-1:PL_BITS];
        r_m4    <= PL_BITS'(r_p3[PL_BITS-1:32]) * PL_BITS'(bfw_pkg::PIX_SQ_MAX);
        r_sp4   <= r_sp3;
        r_zero5 <= r_big4 || (a5 >= A_BITS'(1 << bfw_pkg::EXP_SPAN_BITS));
        r_idx5  <= a5[bfw_pkg::EXP_SPAN_BITS-1 -: bfw_pkg::EXP_IDX_BITS];
        r_rom6  <= EXP_ROM[r_idx5];
        r_zero6 <= r_zero5;
        r_wt7   <= wt6;
        r_prod7 <= (bfw_pkg::WT_BITS+bfw_pkg::PIXEL_BITS)'(wt6) * r_tap[5];
    end

    always_comb begin
        o_wt.valid = r_v[STAGES-1];
        o_wt.wt    = r_wt7;
        o_wt.prod  = r_prod7;
        o_busy     = |r_v;
    end

endmodule

`default_nettype wire

// ===== rtl/bfw_divider.sv =====
// ---------------------------------------------------------------------------
// bfw_divider
// Shift-and-subtract divider, one quotient bit per cycle, for the
// normalized filter output.
// ---------------------------------------------------------------------------
`default_nettype none

module bfw_divider (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [bfw_pkg::PSUM_BITS:0]        i_num,
    input  wire logic [bfw_pkg::WSUM_BITS-1:0]      i_den,
    output logic                                    o_done,
    output logic [bfw_pkg::QUOT_BITS-1:0]           o_quot
);

    localparam int R_BITS = bfw_pkg::PSUM_BITS + 2;
    localparam int C_BITS = $clog2(bfw_pkg::QUOT_BITS);

    logic                            r_busy;
    logic                            r_done;
    logic [C_BITS-1:0]               r_cnt;
    logic [R_BITS-1:0]               r_rem;
    logic [bfw_pkg::WSUM_BITS-1:0]   r_den;
    logic [bfw_pkg::QUOT_BITS-1:0]   r_quot;
    logic [R_BITS-1:0]               den_sh;
    logic                            fits;

    always_comb begin
        den_sh = R_BITS'(r_den) << r_cnt;
        fits   = r_rem >= den_sh;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_BITS'(bfw_pkg::QUOT_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // remainder and quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= R_BITS'(i_num);
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - den_sh;
            end
            r_quot[r_cnt[C_BITS-1:0]] <= fits;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/bilateral_filter_window.sv =====
// ---------------------------------------------------------------------------
// bilateral_filter_window
// Streaming bilateral filter with line stores and a column-cell window.
// ---------------------------------------------------------------------------
// Samples arrive in raster order, padded by radius on each side. Each one
// is taken when no result is being computed; the block then shifts the
// line store and window in the LOAD state. For a full window it weighs
// all (2*radius+1)^2 taps through one pipelined weight unit at one tap per
// cycle, then divides in a serial shift-and-subtract divider; no new
// sample is taken until its result is loaded into the output register.
// The line store needs no clearing after reset.
`default_nettype none

module bilateral_filter_window (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    bfw_in_if.sink                            i_pix,
    bfw_out_if.source                         o_pix,
    input  wire logic                         i_cfg_we,
    input  wire logic [2:0]                   i_cfg_index,
    input  wire logic [bfw_pkg::CFG_BITS-1:0] i_cfg_data
);

    localparam int WB = bfw_pkg::WIN_BITS;

    bfw_pkg::t_state r_state;
    bfw_pkg::t_state n_state;

    logic [bfw_pkg::DIM_BITS-1:0] r_fw;
    logic [bfw_pkg::DIM_BITS-1:0] r_fh;
    logic [bfw_pkg::RAD_BITS-1:0] r_rad;
    logic [bfw_pkg::KS_BITS-1:0]  r_ks;
    logic [bfw_pkg::KR_BITS-1:0]  r_kr;

    logic [bfw_pkg::COL_BITS-1:0] r_col;
    logic [bfw_pkg::ROW_BITS-1:0] r_row;
    bfw_pkg::t_pix                r_pix;
    bfw_pkg::t_lines              r_rd;
    bfw_pkg::t_lines              line_mem [bfw_pkg::MAX_WIDTH];

    logic [WB-1:0]                r_tx;
    logic [WB-1:0]                r_ty;
    logic                         r_last;
    logic [bfw_pkg::WSUM_BITS-1:0] r_wsum;
    logic [bfw_pkg::PSUM_BITS-1:0] r_psum;
    logic                         r_out_valid;
    bfw_pkg::t_pix                r_pixel_out;
    logic                         r_frame_done;

    logic [bfw_pkg::DIM_BITS-1:0] w_cl;
    logic [bfw_pkg::DIM_BITS-1:0] h_cl;
    logic [bfw_pkg::RAD_BITS-1:0] r_cl;
    logic [WB-1:0]                base;
    logic [WB-1:0]                ctr;
    logic                         emit;
    logic                         col_end;
    logic                         row_end;
    logic                         accept;
    logic                         tap_last;
    logic                         div_start;
    logic                         out_load;
    bfw_pkg::t_column             colv;
    bfw_pkg::t_lines              wr_lines;
    bfw_pkg::t_column             cols [bfw_pkg::WIN];
    bfw_pkg::t_tap_req            req;
    bfw_pkg::t_wt_out             wt;
    logic                         wbusy;
    logic                         div_done;
    logic [bfw_pkg::QUOT_BITS-1:0] quot;
    logic [WB-1:0]                dxa;
    logic [WB-1:0]                dya;

    // clamped configuration
    always_comb begin
        w_cl = (r_fw < 13'd3) ? 13'd3 :
               (r_fw > 13'(bfw_pkg::MAX_WIDTH)) ? 13'(bfw_pkg::MAX_WIDTH) : r_fw;
        h_cl = (r_fh < 13'd3) ? 13'd3 :
               (r_fh > 13'(bfw_pkg::MAX_HEIGHT)) ? 13'(bfw_pkg::MAX_HEIGHT) : r_fh;
        r_cl = (r_rad == '0) ? 3'd1 : r_rad;
        base = WB'(bfw_pkg::WIN - 1) - {r_cl, 1'b0};
        ctr  = WB'(bfw_pkg::WIN - 1) - WB'(r_cl);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= 13'd64;
            r_fh  <= 13'd64;
            r_rad <= 3'd1;
            r_ks  <= 16'd128;
            r_kr  <= 24'd12800;
        end else if (i_cfg_we) begin
            case (bfw_pkg::t_cfg_idx'(i_cfg_index))
                bfw_pkg::CFG_FRAME_WIDTH:  r_fw  <= i_cfg_data[bfw_pkg::DIM_BITS-1:0];
                bfw_pkg::CFG_FRAME_HEIGHT: r_fh  <= i_cfg_data[bfw_pkg::DIM_BITS-1:0];
                bfw_pkg::CFG_RADIUS:       r_rad <= i_cfg_data[bfw_pkg::RAD_BITS-1:0];
                bfw_pkg::CFG_SPATIAL_COEF: r_ks  <= i_cfg_data[bfw_pkg::KS_BITS-1:0];
                bfw_pkg::CFG_RANGE_COEF:   r_kr  <= i_cfg_data[bfw_pkg::KR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // position of the current sample
    always_comb begin
        accept   = i_pix.valid && i_pix.ready;
        emit     = (r_row >= 12'({r_cl, 1'b0})) && (r_col >= 12'({r_cl, 1'b0}));
        col_end  = (13'(r_col) + 13'd1) >= w_cl;
        row_end  = (13'(r_row) + 13'd1) >= h_cl;
        tap_last = (r_tx == WB'(bfw_pkg::WIN - 1)) && (r_ty == WB'(bfw_pkg::WIN - 1));
        div_start = (r_state == bfw_pkg::ST_DRAIN) && !wbusy;
        out_load  = (r_state == bfw_pkg::ST_OUT) && (!r_out_valid || o_pix.ready);
    end

    // line store, one row of all lines per column
    always_ff @(posedge i_clk) begin
        r_rd <= line_mem[r_col];
        if (r_state == bfw_pkg::ST_LOAD) begin
            line_mem[r_col] <= wr_lines;
        end
    end

    always_comb begin
        for (int y = 0; y < bfw_pkg::LINES; y++) begin
            colv[y] = r_rd[y];
        end
        colv[bfw_pkg::LINES] = r_pix;
        for (int y = 0; y < bfw_pkg::LINES - 1; y++) begin
            wr_lines[y] = r_rd[y+1];
        end
        wr_lines[bfw_pkg::LINES-1] = r_pix;
    end

    // window as a chain of column cells
    for (genvar x = 0; x < bfw_pkg::WIN; x++) begin : g_cell
        bfw_column_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (r_state == bfw_pkg::ST_LOAD),
            .i_col   ((x == bfw_pkg::WIN - 1) ? colv : cols[(x + 1) % bfw_pkg::WIN]),
            .o_col   (cols[x])
        );
    end

    // counters, sample latch and tap walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (r_state == bfw_pkg::ST_LOAD) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_pix.pixel_in;
        end
        if (r_state == bfw_pkg::ST_LOAD) begin
            r_tx   <= base;
            r_ty   <= base;
            r_last <= col_end && row_end;
        end else if (r_state == bfw_pkg::ST_TAPS) begin
            if (r_tx == WB'(bfw_pkg::WIN - 1)) begin
                r_tx <= base;
                r_ty <= r_ty + 1'b1;
            end else begin
                r_tx <= r_tx + 1'b1;
            end
        end
    end

    // tap request for the weight pipeline
    always_comb begin
        dxa = (r_tx >= ctr) ? r_tx - ctr : ctr - r_tx;
        dya = (r_ty >= ctr) ? r_ty - ctr : ctr - r_ty;
        req.valid  = (r_state == bfw_pkg::ST_TAPS);
        req.tap    = cols[r_tx][r_ty];
        req.centre = cols[ctr][ctr];
        req.dist2  = bfw_pkg::DIST2_BITS'(dxa) * bfw_pkg::DIST2_BITS'(dxa)
                   + bfw_pkg::DIST2_BITS'(dya) * bfw_pkg::DIST2_BITS'(dya);
    end

    bfw_weight_unit u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ks    (r_ks),
        .i_kr    (r_kr),
        .i_req   (req),
        .o_wt    (wt),
        .o_busy  (wbusy)
    );

    // weight and weighted sample sums
    always_ff @(posedge i_clk) begin
        if (r_state == bfw_pkg::ST_LOAD) begin
            r_wsum <= '0;
            r_psum <= '0;
        end else if (wt.valid) begin
            r_wsum <= r_wsum + bfw_pkg::WSUM_BITS'(wt.wt);
            r_psum <= r_psum + bfw_pkg::PSUM_BITS'(wt.prod);
        end
    end

    bfw_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({1'b0, r_psum} + (bfw_pkg::PSUM_BITS+1)'(r_wsum >> 1)),
        .i_den   (r_wsum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bfw_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = bfw_pkg::ST_LOAD;
                end
            end
            bfw_pkg::ST_LOAD: begin
                n_state = emit ? bfw_pkg::ST_TAPS : bfw_pkg::ST_IDLE;
            end
            bfw_pkg::ST_TAPS: begin
                if (tap_last) begin
                    n_state = bfw_pkg::ST_DRAIN;
                end
            end
            bfw_pkg::ST_DRAIN: begin
                if (!wbusy) begin
                    n_state = bfw_pkg::ST_DIV;
                end
            end
            bfw_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = bfw_pkg::ST_OUT;
                end
            end
            bfw_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = bfw_pkg::ST_IDLE;
                end
            end
            default: n_state = bfw_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_pixel_out  <= quot[bfw_pkg::QUOT_BITS-1] ? '1
                                                       : quot[bfw_pkg::PIXEL_BITS-1:0];
            r_frame_done <= r_last;
        end
    end

    assign i_pix.ready      = (r_state == bfw_pkg::ST_IDLE);
    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_out  = r_pixel_out;
    assign o_pix.frame_done = r_frame_done;

endmodule

`default_nettype wire

// ===== rtl/bfw_checker.sv =====
// ---------------------------------------------------------------------------
// bfw_checker
// Port-level checks of the bilateral filter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bfw_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_ready,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire bfw_pkg::t_pix i_pixel_out,
    input wire logic          i_frame_done
);

    // result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_pixel_out) && $stable(i_frame_done))
        else $error("result changed while stalled");

    // one sample at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while previous one in work");

    // a result never rises in the cycle after a sample is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result appeared too early");

endmodule

bind bilateral_filter_window bfw_checker u_bfw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_pix.valid),
    .i_out_ready  (o_pix.ready),
    .i_pixel_out  (o_pix.pixel_out),
    .i_frame_done (o_pix.frame_done)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming bilateral filter: whole padded
// frames go in under random handshake idling, a scoreboard class predicts
// every filtered pixel and frame_done flag, and outputs are compared in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int IDLE_LIMIT = 12000;
    localparam int LONG_HOLD  = 3000;
    localparam int SETTLE     = 300;
    localparam int ITEM_GOAL  = 1900;

    typedef struct {
        logic [15:0] pixel_out;
        logic        frame_done;
    } t_expect;

    // scoreboard: mirror of the filter state and the queue of expected pixels
    class bf_scoreboard;
        logic [12:0]     width_reg;
        logic [12:0]     height_reg;
        logic [2:0]      radius_reg;
        logic [15:0]     ks_reg;
        logic [23:0]     kr_reg;
        logic [15:0]     lines [bfw_pkg::LINES][bfw_pkg::MAX_WIDTH];
        logic [15:0]     win [bfw_pkg::WIN][bfw_pkg::WIN];
        int unsigned     col_cnt;
        int unsigned     row_cnt;
        int unsigned     weight_rom [bfw_pkg::EXP_DEPTH];
        t_expect         expected_pixels [$];
        int              errors;
        int              n_in;
        int              n_out;
        int              n_frames;

        function new();
            longint unsigned one;
            longint unsigned h;
            longint unsigned t;
            longint unsigned e;
            longint unsigned q;
            width_reg  = 13'd64;
            height_reg = 13'd64;
            radius_reg = 3'd1;
            ks_reg     = 16'd128;
            kr_reg     = 24'd12800;
            col_cnt    = 0;
            row_cnt    = 0;
            errors     = 0;
            n_in       = 0;
            n_out      = 0;
            n_frames   = 0;
            // exp(-16*i/depth) in Q16 from a Q32 taylor step
            one = 64'd1 << 32;
            h   = (64'd16 << 32) / bfw_pkg::EXP_DEPTH;
            t   = one;
            e   = one;
            q   = one;
            for (int k = 1; k <= 10; k++) begin
                t = ((t * h) >> 32) / longint'(k);
                e = (k % 2 == 1) ? e - t : e + t;
            end
            for (int i = 0; i < bfw_pkg::EXP_DEPTH; i++) begin
                weight_rom[i] = int'((q + 64'd32768) >> 16);
                q = (q * e + (64'd1 << 31)) >> 32;
            end
        endfunction

        function void set_reg(bfw_pkg::t_cfg_idx idx, logic [23:0] val);
            case (idx)
                bfw_pkg::CFG_FRAME_WIDTH:  width_reg  = val[12:0];
                bfw_pkg::CFG_FRAME_HEIGHT: height_reg = val[12:0];
                bfw_pkg::CFG_RADIUS:       radius_reg = val[2:0];
                bfw_pkg::CFG_SPATIAL_COEF: ks_reg     = val[15:0];
                bfw_pkg::CFG_RANGE_COEF:   kr_reg     = val[23:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // one accepted sample: shift stores, predict a result for a full window
        function void note_sample(logic [15:0] pix);
            int unsigned     w, hgt, r, col, row, c, s2;
            int              dx, dy;
            logic [15:0]     colv [bfw_pkg::WIN];
            longint unsigned centre, tap, d, a, wt, wsum, psum, res;
            longint unsigned mm;
            t_expect         ex;
            w   = clamp(width_reg, 3, bfw_pkg::MAX_WIDTH);
            hgt = clamp(height_reg, 3, bfw_pkg::MAX_HEIGHT);
            r   = clamp(radius_reg, 1, bfw_pkg::MAX_RADIUS);
            col = col_cnt % bfw_pkg::MAX_WIDTH;
            row = row_cnt;
            mm  = 64'd65535 * 64'd65535;
            n_in++;
            for (int y = 0; y < bfw_pkg::LINES; y++) colv[y] = lines[y][col];
            colv[bfw_pkg::LINES] = pix;
            for (int y = 0; y + 1 < bfw_pkg::LINES; y++) lines[y][col] = lines[y+1][col];
            lines[bfw_pkg::LINES-1][col] = pix;
            for (int y = 0; y < bfw_pkg::WIN; y++) begin
                for (int x = 0; x + 1 < bfw_pkg::WIN; x++) win[y][x] = win[y][x+1];
                win[y][bfw_pkg::WIN-1] = colv[y];
            end
            if (row >= 2 * r && col >= 2 * r) begin
                c      = (bfw_pkg::WIN - 1) - r;
                centre = win[c][c];
                wsum   = 0;
                psum   = 0;
                for (int y = (bfw_pkg::WIN - 1) - 2 * r; y < bfw_pkg::WIN; y++) begin
                    for (int x = (bfw_pkg::WIN - 1) - 2 * r; x < bfw_pkg::WIN; x++) begin
                        tap = win[y][x];
                        dy  = y - int'(c);
                        dx  = x - int'(c);
                        s2  = dx * dx + dy * dy;
                        d   = tap > centre ? tap - centre : centre - tap;
                        a   = longint'(ks_reg) * s2 + (longint'(kr_reg) * d * d) / mm;
                        wt  = (a < 4096) ? weight_rom[(a * bfw_pkg::EXP_DEPTH) >> 12] : 0;
                        wsum += wt;
                        psum += wt * tap;
                    end
                end
                res = (psum + wsum / 2) / wsum;
                if (res > 65535) res = 65535;
                ex.pixel_out  = res[15:0];
                ex.frame_done = (col + 1 >= w && row + 1 >= hgt);
                expected_pixels.push_back(ex);
            end
            if (col + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (row + 1 >= hgt) ? 0 : row + 1;
            end else begin
                col_cnt = col + 1;
            end
        endfunction

        function void check_pixel(logic [15:0] pixel_out, logic frame_done);
            t_expect ex;
            n_out++;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result pixel_out=%0d frame_done=%0d", pixel_out, frame_done);
                errors++;
                return;
            end
            ex = expected_pixels.pop_front();
            if (pixel_out !== ex.pixel_out) begin
                $error("pixel_out expected %0d actual %0d", ex.pixel_out, pixel_out);
                errors++;
            end
            if (frame_done !== ex.frame_done) begin
                $error("frame_done expected %0d actual %0d", ex.frame_done, frame_done);
                errors++;
            end
            if (frame_done === 1'b1) n_frames++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    bfw_in_if  pix_in_if ();
    bfw_out_if pix_out_if ();

    bilateral_filter_window u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_in_if),
        .o_pix       (pix_out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bf_scoreboard sb;
    bit           in_idle_en;
    bit           out_idle_en;
    bit           hold_long;
    int           samples_sent;
    int           idle_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // known values on every input from time zero
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = bfw_pkg::CFG_FRAME_WIDTH;
        i_cfg_data         = '0;
        pix_in_if.valid    = 1'b0;
        pix_in_if.pixel_in = '0;
        pix_out_if.ready   = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out_if.valid && pix_out_if.ready)
            sb.check_pixel(pix_out_if.pixel_out, pix_out_if.frame_done);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // result receiver with random stalls and one long hold-off
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = out_idle_en ? $urandom_range(0, 14) : 0;
            if (hold_long) begin
                pix_out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_long = 1'b0;
            end else if (gap > 0) begin
                pix_out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pix_out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!pix_out_if.valid);
        end
    end

    task automatic write_filter_cfg(logic [12:0] w, logic [12:0] h, logic [2:0] r,
                                    logic [15:0] ks, logic [23:0] kr);
        logic [23:0]       vals [5];
        bfw_pkg::t_cfg_idx idx;
        vals = '{24'(w), 24'(h), 24'(r), 24'(ks), kr};
        for (int i = 0; i < 5; i++) begin
            idx = bfw_pkg::t_cfg_idx'(i);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.set_reg(idx, vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(logic [15:0] pix);
        int gap;
        gap = in_idle_en ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            pix_in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in_if.valid    <= 1'b1;
        pix_in_if.pixel_in <= pix;
        do @(posedge i_clk); while (!pix_in_if.ready);
        sb.note_sample(pix);
        samples_sent++;
    endtask

    // wait for every expected pixel, then let in-flight work settle
    task automatic drain_results();
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] make_pixel(int style, int x, int y, int base);
        case (style)
            0: return 16'($urandom);
            1: return 16'(base + x * 1500 + y * 900 + $urandom_range(0, 2000));
            2: return ((x + y) % 2) ? 16'hFFFF : 16'h0000;
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // one configuration, then whole frames
    task automatic run_frames(logic [12:0] w, logic [12:0] h, logic [2:0] r,
                              logic [15:0] ks, logic [23:0] kr, int frames, int style);
        int wc, hc, base;
        drain_results();
        write_filter_cfg(w, h, r, ks, kr);
        wc = sb.clamp(w, 3, bfw_pkg::MAX_WIDTH);
        hc = sb.clamp(h, 3, bfw_pkg::MAX_HEIGHT);
        for (int f = 0; f < frames; f++) begin
            base = $urandom;
            for (int y = 0; y < hc; y++)
                for (int x = 0; x < wc; x++)
                    send_sample(make_pixel(style, x, y, base));
        end
        pix_in_if.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_ks();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    function automatic logic [23:0] pick_kr();
        case ($urandom_range(0, 4))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 40000));
        endcase
    endfunction

    // main sequence
    initial begin
        int r, w, h;
        sb           = new();
        in_idle_en   = 1'b1;
        out_idle_en  = 1'b1;
        hold_long    = 1'b0;
        samples_sent = 0;
        idle_cycles  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clamped registers, zero and full-scale coefficients
        run_frames(13'd0, 13'd0, 3'd0, 16'd0, 24'd0, 1, 2);
        run_frames(13'd3, 13'd3, 3'd1, 16'hFFFF, 24'hFFFFFF, 1, 3);
        // window larger than the frame, no result expected
        run_frames(13'd5, 13'd4, 3'd7, 16'd128, 24'd12800, 1, 0);

        // full radius with the receiver held off while samples keep coming
        hold_long = 1'b1;
        run_frames(13'd17, 13'd16, 3'd7, 16'd64, 24'd30000, 1, 1);

        // random frames
        while (samples_sent < ITEM_GOAL) begin
            in_idle_en  = ($urandom_range(0, 9) < 7);
            out_idle_en = ($urandom_range(0, 9) < 7);
            r = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
            w = 2 * r + 1 + $urandom_range(0, 6);
            h = 2 * r + 1 + $urandom_range(0, 4);
            if ($urandom_range(0, 15) == 0) w = $urandom_range(3, 2 * r);
            if ($urandom_range(0, 15) == 0) r = 0;
            run_frames(13'(w), 13'(h), 3'(r), pick_ks(), pick_kr(),
                       $urandom_range(1, 2), $urandom_range(0, 3));
        end

        drain_results();
        $display("run covered %0d samples, %0d filtered pixels, %0d completed frames",
                 sb.n_in, sb.n_out, sb.n_frames);
        if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
